// File: src/assert_macros.svh
// Assertion macros shared by the crossover and mutation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define WCM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define WCM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/wcm_pkg.sv
// Types and constants of the weight crossover and mutation block.
package wcm_pkg;

   localparam int WEIGHT_BITS   = 16;
   localparam int RANDOM_BITS   = 16;
   // mutation arithmetic is done this wide so compares against the bounds stay exact
   localparam int MUT_BITS      = WEIGHT_BITS + 4;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef logic signed [WEIGHT_BITS-1:0] weight_type;
   typedef logic        [RANDOM_BITS-1:0] rand_type;
   typedef logic signed [MUT_BITS-1:0]    mut_weight_type;

   localparam weight_type WEIGHT_MIN_RESET    = weight_type'(-4096);
   localparam weight_type WEIGHT_MAX_RESET    = weight_type'(4096);
   localparam rand_type   MUTATION_RATE_RESET = rand_type'(6554);

   typedef enum logic [1:0] {
      REG_WEIGHT_MIN    = 2'd0,
      REG_WEIGHT_MAX    = 2'd1,
      REG_MUTATION_RATE = 2'd2
   } reg_index_type;

   typedef struct packed {
      weight_type parent_one;
      weight_type parent_two;
      rand_type   gate_rand_a;
      rand_type   sign_rand_a;
      rand_type   step_rand_a;
      rand_type   gate_rand_b;
      rand_type   sign_rand_b;
      rand_type   step_rand_b;
   } req_payload_type;

   typedef struct packed {
      weight_type child_a;
      weight_type child_b;
      logic       mutated_a;
      logic       mutated_b;
   } rsp_payload_type;

   // bounds and rate as seen by the mutation units
   typedef struct packed {
      weight_type weight_min;
      weight_type weight_max;
      rand_type   mutation_rate;
   } cfg_type;

   typedef struct packed {
      rand_type gate_rand;
      rand_type sign_rand;
      rand_type step_rand;
   } mut_rand_type;

endpackage

// File: src/wcm_mutate.sv
// Wraparound mutation of one child weight.
module wcm_mutate (
   input  wcm_pkg::cfg_type        cfg,
   input  wcm_pkg::mut_weight_type weight_in,
   input  wcm_pkg::mut_rand_type   rnd,
   output wcm_pkg::weight_type     weight_out,
   output logic                    mutated
);

   localparam int W = wcm_pkg::WEIGHT_BITS;
   localparam int R = wcm_pkg::RANDOM_BITS;
   localparam int M = wcm_pkg::MUT_BITS;

   logic signed [W:0]       range;
   logic signed [R+W+1:0]   product;
   logic signed [W:0]       step;
   wcm_pkg::mut_weight_type step_ext;
   wcm_pkg::mut_weight_type range_ext;
   wcm_pkg::mut_weight_type max_ext;
   wcm_pkg::mut_weight_type min_ext;
   wcm_pkg::mut_weight_type plus_sum;
   wcm_pkg::mut_weight_type minus_sum;
   wcm_pkg::mut_weight_type plus_res;
   wcm_pkg::mut_weight_type minus_res;
   wcm_pkg::mut_weight_type result;
   logic                    gate_hit;
   logic                    go_plus;

   assign range   = (W+1)'(cfg.weight_max) - (W+1)'(cfg.weight_min);
   assign product = $signed({1'b0, rnd.step_rand}) * range;
   // the upper bits of the product are the floor of product / 2^(R+1)
   assign step    = $signed(product[R+W+1:R+1]);

   assign step_ext  = M'(step);
   assign range_ext = M'(range);
   assign max_ext   = M'(cfg.weight_max);
   assign min_ext   = M'(cfg.weight_min);

   assign gate_hit = (rnd.gate_rand <= cfg.mutation_rate);
   // exactly half counts as minus
   assign go_plus  = rnd.sign_rand[R-1] & (|rnd.sign_rand[R-2:0]);

   assign plus_sum  = weight_in + step_ext;
   assign minus_sum = weight_in - step_ext;
   assign plus_res  = (plus_sum > max_ext) ? plus_sum - range_ext : plus_sum;
   assign minus_res = (minus_sum < min_ext) ? minus_sum + range_ext : minus_sum;

   always_comb begin
      if (!gate_hit) begin
         result = weight_in;
      end else if (go_plus) begin
         result = plus_res;
      end else begin
         result = minus_res;
      end
   end

   assign weight_out = $signed(result[W-1:0]);
   assign mutated    = gate_hit;

endmodule

// File: src/weight_crossover_mutation_top.sv
// Top level of the weight crossover and mutation block.
//
// Usage: each item on the req_ channel carries two parent weights (signed Q4.12)
// and six random fractions; each item yields exactly one result on the rsp_
// channel with child_a (floor average of the parents), child_b (average moved
// by half the bound range across the midpoint, alternating max/min on an exact
// midpoint tie) and a mutated flag per child.
// Both channels use valid/ready; an item moves when valid and ready are high.
// Path: an accepted item enters the input register, then passes the crossover
// and mutation logic, with one multiply per child, into the result register.
// Throughput: one item per cycle while rsp_ready is high.
// A stalled rsp_ready holds the result register; the input register still takes
// one more item, then req_ready drops until the result is taken.
// Reset empties both registers, loads the bound and rate registers with their
// defaults and sets the tie flag so the first tie gives weight_max.
// Configuration: APB-style port, weight_min at 0x0, weight_max at 0x4,
// mutation_rate at 0x8; write only while no item is in flight.
`include "assert_macros.svh"

module weight_crossover_mutation_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wcm_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wcm_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wcm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [wcm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [wcm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   localparam int W = wcm_pkg::WEIGHT_BITS;
   localparam int M = wcm_pkg::MUT_BITS;
   localparam int D = wcm_pkg::CSR_DATA_BITS;

   // configuration registers
   wcm_pkg::weight_type      weight_min_ff, weight_min_in;
   wcm_pkg::weight_type      weight_max_ff, weight_max_in;
   wcm_pkg::rand_type        mutation_rate_ff, mutation_rate_in;
   wcm_pkg::reg_index_type   csr_index;
   logic                     csr_write;

   // pipeline registers
   logic                     s1_valid_ff, s1_valid_in;
   wcm_pkg::req_payload_type s1_ff, s1_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   wcm_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                     tie_pick_max_ff, tie_pick_max_in;

   logic                     advance;
   logic                     take;

   // crossover
   logic signed [W:0]        parent_sum;
   wcm_pkg::weight_type      avg;
   logic signed [W:0]        twice_avg;
   logic signed [W:0]        mid2;
   logic signed [W:0]        range;
   logic signed [W+1:0]      far_down;
   logic signed [W+1:0]      far_up;
   logic                     tie;
   wcm_pkg::mut_weight_type  cross_a;
   wcm_pkg::mut_weight_type  cross_b;
   wcm_pkg::cfg_type         cfg;
   wcm_pkg::mut_rand_type    rnd_a;
   wcm_pkg::mut_rand_type    rnd_b;
   wcm_pkg::weight_type      child_a;
   wcm_pkg::weight_type      child_b;
   logic                     mutated_a;
   logic                     mutated_b;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = wcm_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      weight_min_in    = weight_min_ff;
      weight_max_in    = weight_max_ff;
      mutation_rate_in = mutation_rate_ff;
      csr_prdata       = '0;
      unique case (csr_index)
         wcm_pkg::REG_WEIGHT_MIN: begin
            csr_prdata = D'(weight_min_ff);
            if (csr_write) begin
               weight_min_in = $signed(csr_pwdata[W-1:0]);
            end
         end
         wcm_pkg::REG_WEIGHT_MAX: begin
            csr_prdata = D'(weight_max_ff);
            if (csr_write) begin
               weight_max_in = $signed(csr_pwdata[W-1:0]);
            end
         end
         wcm_pkg::REG_MUTATION_RATE: begin
            csr_prdata = D'(mutation_rate_ff);
            if (csr_write) begin
               mutation_rate_in = csr_pwdata[wcm_pkg::RANDOM_BITS-1:0];
            end
         end
         default: begin
            // unmapped address: drop the write, read zero
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_min_ff    <= wcm_pkg::WEIGHT_MIN_RESET;
         weight_max_ff    <= wcm_pkg::WEIGHT_MAX_RESET;
         mutation_rate_ff <= wcm_pkg::MUTATION_RATE_RESET;
      end else begin
         weight_min_ff    <= weight_min_in;
         weight_max_ff    <= weight_max_in;
         mutation_rate_ff <= mutation_rate_in;
      end
   end

   // ---------------- handshake ----------------
   assign advance   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | advance;
   assign take      = req_valid & req_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------- crossover ----------------
   assign parent_sum = (W+1)'(s1_ff.parent_one) + (W+1)'(s1_ff.parent_two);
   assign avg        = $signed(parent_sum[W:1]);
   assign twice_avg  = $signed({avg, 1'b0});
   assign mid2       = (W+1)'(weight_max_ff) + (W+1)'(weight_min_ff);
   assign range      = (W+1)'(weight_max_ff) - (W+1)'(weight_min_ff);
   assign far_down   = (W+2)'(twice_avg) - (W+2)'(range);
   assign far_up     = (W+2)'(twice_avg) + (W+2)'(range);
   assign tie        = (twice_avg == mid2);

   assign cross_a = M'(avg);

   always_comb begin
      if (twice_avg > mid2) begin
         cross_b = M'($signed(far_down[W+1:1]));
      end else if (twice_avg < mid2) begin
         cross_b = M'($signed(far_up[W+1:1]));
      end else if (tie_pick_max_ff) begin
         cross_b = M'(weight_max_ff);
      end else begin
         cross_b = M'(weight_min_ff);
      end
   end

   // ---------------- mutation ----------------
   assign cfg.weight_min    = weight_min_ff;
   assign cfg.weight_max    = weight_max_ff;
   assign cfg.mutation_rate = mutation_rate_ff;

   assign rnd_a.gate_rand = s1_ff.gate_rand_a;
   assign rnd_a.sign_rand = s1_ff.sign_rand_a;
   assign rnd_a.step_rand = s1_ff.step_rand_a;
   assign rnd_b.gate_rand = s1_ff.gate_rand_b;
   assign rnd_b.sign_rand = s1_ff.sign_rand_b;
   assign rnd_b.step_rand = s1_ff.step_rand_b;

   wcm_mutate u_mutate_a (
      .cfg        (cfg),
      .weight_in  (cross_a),
      .rnd        (rnd_a),
      .weight_out (child_a),
      .mutated    (mutated_a)
   );

   wcm_mutate u_mutate_b (
      .cfg        (cfg),
      .weight_in  (cross_b),
      .rnd        (rnd_b),
      .weight_out (child_b),
      .mutated    (mutated_b)
   );

   // ---------------- pipeline registers ----------------
   always_comb begin
      s1_valid_in     = s1_valid_ff;
      s1_in           = s1_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;
      tie_pick_max_in = tie_pick_max_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in     = 1'b1;
         rsp_in.child_a   = child_a;
         rsp_in.child_b   = child_b;
         rsp_in.mutated_a = mutated_a;
         rsp_in.mutated_b = mutated_b;
         s1_valid_in      = 1'b0;
         // flip the tie choice only when an item actually lands on the midpoint
         if (tie) begin
            tie_pick_max_in = ~tie_pick_max_ff;
         end
      end
      if (take) begin
         s1_valid_in = 1'b1;
         s1_in       = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         tie_pick_max_ff <= 1'b1;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         tie_pick_max_ff <= tie_pick_max_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   // ---------------- assertions ----------------
   `WCM_ASSERT(a_tie_toggles, (advance && tie) |=> (tie_pick_max_ff != $past(tie_pick_max_ff)), "tie flag did not flip on a midpoint tie")
   `WCM_ASSERT(a_tie_holds, !(advance && tie) |=> $stable(tie_pick_max_ff), "tie flag changed without a tie")
   `WCM_ASSERT(a_ready_when_empty, !s1_valid_ff |-> req_ready, "input register empty but not ready")
   `WCM_ASSERT(a_advance_loads_rsp, advance |=> rsp_valid_ff, "advanced item did not reach the result register")
   `WCM_ASSERT_ALWAYS(a_reset_empties, reset |=> (!s1_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")

endmodule
